>>> src/u8dec_pkg.sv
// shared types and constants of the utf-8 to 16-bit character decoder
package u8dec_pkg;

   localparam int OUT_W       = 32;
   localparam int CHAR_W      = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OUT_W-1:0]  OUT_MAX       = 32'hFFFF_FFFF;
   localparam logic [CHAR_W-1:0] MIN_TWO_BYTE  = 16'h0080;
   localparam logic [CHAR_W-1:0] MIN_THREE_BYTE = 16'h0800;

   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] ASCII_CODE = 8'h00;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   typedef enum logic [2:0] {
      KIND_ASCII   = 3'd0,
      KIND_LEAD2   = 3'd1,
      KIND_LEAD3   = 3'd2,
      KIND_LEAD4   = 3'd3,
      KIND_CONT    = 3'd4,
      KIND_INVALID = 3'd5
   } byte_kind_type;

   typedef enum logic [3:0] {
      SEQ_NONE  = 4'b0001,
      SEQ_TWO   = 4'b0010,
      SEQ_THREE = 4'b0100,
      SEQ_FOUR  = 4'b1000
   } seq_len_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } u8dec_req_type;

   typedef struct packed {
      logic              char_valid;
      logic [CHAR_W-1:0] character;
      logic              done_res;
      logic [OUT_W-1:0]  bytes_consumed;
      logic [OUT_W-1:0]  characters_made;
   } u8dec_rsp_type;

   typedef struct packed {
      byte_kind_type kind;
      logic [6:0]    bits;
      logic          last;
   } u8dec_item_type;

   function automatic logic [2:0] seq_bytes(input seq_len_type len);
      logic [2:0] n;
      case (len)
         SEQ_TWO:   n = 3'd2;
         SEQ_THREE: n = 3'd3;
         SEQ_FOUR:  n = 3'd4;
         default:   n = 3'd1;
      endcase
      return n;
   endfunction

endpackage

>>> src/u8dec_front.sv
// front end: accepts input bytes and classifies them for the queue
module u8dec_front (
   input  logic                    req_valid,
   output logic                    req_ready,
   input  u8dec_pkg::u8dec_req_type req_data,
   input  logic                    queue_full,
   output logic                    push,
   output u8dec_pkg::u8dec_item_type push_item
);
   import u8dec_pkg::*;

   byte_kind_type kind;

   always_comb begin
      if ((req_data.data_byte & ASCII_MASK) == ASCII_CODE) begin
         kind = KIND_ASCII;
      end else if ((req_data.data_byte & CONT_MASK) == CONT_CODE) begin
         kind = KIND_CONT;
      end else if ((req_data.data_byte & LEAD2_MASK) == LEAD2_CODE) begin
         kind = KIND_LEAD2;
      end else if ((req_data.data_byte & LEAD3_MASK) == LEAD3_CODE) begin
         kind = KIND_LEAD3;
      end else if ((req_data.data_byte & LEAD4_MASK) == LEAD4_CODE) begin
         kind = KIND_LEAD4;
      end else begin
         kind = KIND_INVALID;
      end
   end

   assign req_ready      = !queue_full;
   assign push           = req_valid && !queue_full;
   assign push_item.kind = kind;
   assign push_item.bits = req_data.data_byte[6:0];
   assign push_item.last = req_data.last;

endmodule

>>> src/u8dec_queue.sv
// short queue of classified bytes between front and back
module u8dec_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  u8dec_pkg::u8dec_item_type push_item,
   input  logic                      pop,
   output logic                      full,
   output logic                      not_empty,
   output u8dec_pkg::u8dec_item_type head_item
);
   import u8dec_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   u8dec_item_type   entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/u8dec_back.sv
// back end: sequence decoding, counters and the result register
module u8dec_back #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [31:0]               max_chars,
   input  logic                      item_valid,
   input  u8dec_pkg::u8dec_item_type item,
   output logic                      item_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output u8dec_pkg::u8dec_rsp_type  rsp_data
);
   import u8dec_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

   logic [COUNT_WIDTH-1:0] committed_ff, committed_in;
   logic [COUNT_WIDTH-1:0] emitted_ff, emitted_in;
   seq_len_type            seq_ff, seq_in;
   logic [1:0]             rem_ff, rem_in;
   logic [CHAR_W-1:0]      partial_ff, partial_in;
   logic                   stopped_ff, stopped_in;
   logic                   rsp_valid_ff;
   u8dec_rsp_type          rsp_data_ff, rsp_in;

   logic                   at_cap;
   logic                   emit;
   logic                   commit;
   logic [2:0]             commit_n;
   logic [CHAR_W-1:0]      ch;
   logic [CHAR_W-1:0]      shifted;
   logic [COUNT_WIDTH:0]   commit_sum;
   logic [COUNT_WIDTH:0]   emit_sum;
   logic [COUNT_WIDTH-1:0] committed_next;
   logic [COUNT_WIDTH-1:0] emitted_next;
   logic                   has_result;

   assign item_pop   = item_valid && (!rsp_valid_ff || rsp_ready);
   assign at_cap     = CMP_W'(emitted_ff) >= CMP_W'(max_chars);
   assign shifted    = {partial_ff[9:0], item.bits[5:0]};
   assign commit_sum = {1'b0, committed_ff} + (COUNT_WIDTH + 1)'(commit_n);
   assign emit_sum   = {1'b0, emitted_ff} + (COUNT_WIDTH + 1)'(1);

   always_comb begin
      seq_in     = seq_ff;
      rem_in     = rem_ff;
      partial_in = partial_ff;
      stopped_in = stopped_ff;
      emit       = 1'b0;
      commit     = 1'b0;
      commit_n   = 3'd0;
      ch         = '0;
      if (!stopped_ff) begin
         if (seq_ff == SEQ_NONE) begin
            if (at_cap) begin
               stopped_in = 1'b1;
            end else begin
               unique case (item.kind)
                  KIND_ASCII: begin
                     emit     = 1'b1;
                     ch       = CHAR_W'(item.bits);
                     commit   = 1'b1;
                     commit_n = seq_bytes(SEQ_NONE);
                  end
                  KIND_LEAD2: begin
                     seq_in     = SEQ_TWO;
                     rem_in     = 2'd1;
                     partial_in = CHAR_W'(item.bits[4:0]);
                  end
                  KIND_LEAD3: begin
                     seq_in     = SEQ_THREE;
                     rem_in     = 2'd2;
                     partial_in = CHAR_W'(item.bits[3:0]);
                  end
                  KIND_LEAD4: begin
                     seq_in     = SEQ_FOUR;
                     rem_in     = 2'd3;
                     partial_in = '0;
                  end
                  default: begin
                     stopped_in = 1'b1;
                  end
               endcase
               if (!stopped_in && seq_in != SEQ_NONE && item.last) begin
                  stopped_in = 1'b1;
               end
            end
         end else if (seq_ff != SEQ_FOUR && item.kind != KIND_CONT) begin
            stopped_in = 1'b1;
         end else begin
            if (seq_ff != SEQ_FOUR) begin
               partial_in = shifted;
            end
            rem_in = rem_ff - 2'd1;
            if (rem_in != 2'd0) begin
               if (item.last) begin
                  stopped_in = 1'b1;
               end
            end else if (seq_ff == SEQ_TWO && partial_in < MIN_TWO_BYTE) begin
               stopped_in = 1'b1;
            end else if (seq_ff == SEQ_THREE && partial_in < MIN_THREE_BYTE) begin
               stopped_in = 1'b1;
            end else begin
               commit   = 1'b1;
               commit_n = seq_bytes(seq_ff);
               if (seq_ff != SEQ_FOUR) begin
                  emit = 1'b1;
                  ch   = partial_in;
               end
               seq_in     = SEQ_NONE;
               partial_in = '0;
            end
         end
      end
      // buffer end returns to the idle state
      if (item.last) begin
         seq_in     = SEQ_NONE;
         rem_in     = 2'd0;
         partial_in = '0;
         stopped_in = 1'b0;
      end
   end

   always_comb begin
      committed_next = committed_ff;
      emitted_next   = emitted_ff;
      if (commit) begin
         committed_next = commit_sum[COUNT_WIDTH] ? '1 : commit_sum[COUNT_WIDTH-1:0];
      end
      if (emit) begin
         emitted_next = emit_sum[COUNT_WIDTH] ? '1 : emit_sum[COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      has_result          = emit || item.last;
      rsp_in.char_valid   = emit;
      rsp_in.character    = ch;
      rsp_in.done_res     = item.last;
      rsp_in.bytes_consumed  = '0;
      rsp_in.characters_made = '0;
      if (item.last) begin
         rsp_in.bytes_consumed = (CMP_W'(committed_next) > CMP_W'(OUT_MAX)) ?
                                 OUT_MAX : OUT_W'(CMP_W'(committed_next));
         rsp_in.characters_made = (CMP_W'(emitted_next) > CMP_W'(OUT_MAX)) ?
                                  OUT_MAX : OUT_W'(CMP_W'(emitted_next));
      end
      committed_in = committed_next;
      emitted_in   = emitted_next;
      if (item.last) begin
         committed_in = '0;
         emitted_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff <= '0;
         emitted_ff   <= '0;
         seq_ff       <= SEQ_NONE;
         rem_ff       <= 2'd0;
         partial_ff   <= '0;
         stopped_ff   <= 1'b0;
      end else if (item_pop) begin
         committed_ff <= committed_in;
         emitted_ff   <= emitted_in;
         seq_ff       <= seq_in;
         rem_ff       <= rem_in;
         partial_ff   <= partial_in;
         stopped_ff   <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_pop && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && has_result) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.char_valid || rsp_data_ff.done_res))
      else $error("result register holds a transaction with nothing to report");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.char_valid) |-> (rsp_data_ff.character == '0))
      else $error("character not zero without a decoded character");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.done_res) |->
      (rsp_data_ff.bytes_consumed == '0 && rsp_data_ff.characters_made == '0))
      else $error("counts reported before buffer end");

   assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_NONE) |-> (rem_ff == 2'd0))
      else $error("continuation bytes expected with no open sequence");

   assert property (@(posedge clock) disable iff (reset)
      (item_pop && item.last) |=>
      (committed_ff == '0 && emitted_ff == '0 && !stopped_ff && seq_ff == SEQ_NONE))
      else $error("state not cleared after buffer end");

endmodule

>>> src/utf8_to_ucs2_stream_decoder_top.sv
// top level of the utf-8 to 16-bit character stream decoder
// Decodes one UTF-8 byte per transaction into 16-bit characters; a transaction on rsp_ carries
// a character, the byte and character counts on the byte flagged last, or both. The block
// sustains one byte per clock while rsp_ is not stalled: the front classifies each byte into a
// two-entry queue and the back updates the sequence state and saturating counters. The result
// register loads at the edge that pops the byte from the queue, so a byte passes through its
// queue entry and then the result register before rsp_valid rises. A stall on rsp_ fills the
// queue and then drops req_ready. The user writes max_characters through csr_wr_en/csr_wr_data
// only while no buffer is in flight; the block does not enforce this. It resets to all ones.
module utf8_to_ucs2_stream_decoder_top #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  u8dec_pkg::u8dec_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output u8dec_pkg::u8dec_rsp_type rsp_data,
   input  logic                     csr_wr_en,
   input  logic [31:0]              csr_wr_data
);
   import u8dec_pkg::*;

   logic [OUT_W-1:0] max_chars_ff;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_not_empty;
   u8dec_item_type   push_item;
   u8dec_item_type   head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= OUT_MAX;
      end else if (csr_wr_en) begin
         max_chars_ff <= csr_wr_data;
      end
   end

   u8dec_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   u8dec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   u8dec_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .max_chars  (max_chars_ff),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .item_pop   (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> test/ucs2_result_monitor.sv
`timescale 1ns / 1ps
// transaction monitor that predicts and compares decoded characters and buffer counts
module ucs2_result_monitor (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  u8dec_pkg::u8dec_req_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  u8dec_pkg::u8dec_rsp_type rsp_data,
   input  logic                     csr_wr_en,
   input  logic [31:0]              csr_wr_data,
   output int                       mismatches,
   output int                       outstanding
);
   import u8dec_pkg::*;

   logic [31:0]   char_limit = OUT_MAX;
   logic [31:0]   cnt_bytes;
   logic [31:0]   cnt_chars;
   seq_len_type   open_len;
   logic [1:0]    need_cont;
   logic [15:0]   gathered;
   bit            halted;
   u8dec_rsp_type expected_q[$];
   int            fail_total = 0;
   int            waiting = 0;

   assign mismatches  = fail_total;
   assign outstanding = waiting;

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      fail_total++;
      if (fail_total <= 60) begin
         $display("mismatch on %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
      end
   endtask

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      return (a > OUT_MAX - b) ? OUT_MAX : a + b;
   endfunction

   task automatic clear_buffer_state();
      cnt_bytes = '0;
      cnt_chars = '0;
      open_len  = SEQ_NONE;
      need_cont = '0;
      gathered  = '0;
      halted    = 1'b0;
   endtask

   // one byte through the decoder state; yields at most one transaction
   task automatic decode_byte(input u8dec_req_type item, output bit has_res,
                              output u8dec_rsp_type res);
      logic [7:0]  b;
      logic [15:0] ch;
      bit          emit;
      int          span;
      b    = item.data_byte;
      ch   = '0;
      emit = 1'b0;
      res  = '0;
      if (!halted) begin
         if (open_len == SEQ_NONE) begin
            if (cnt_chars >= char_limit) begin
               halted = 1'b1;
            end else if ((b & ASCII_MASK) == ASCII_CODE) begin
               ch        = {8'h00, b};
               emit      = 1'b1;
               cnt_bytes = sat_add(cnt_bytes, 32'd1);
            end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
               open_len  = SEQ_TWO;
               need_cont = 2'd1;
               gathered  = {11'b0, b[4:0]};
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
               open_len  = SEQ_THREE;
               need_cont = 2'd2;
               gathered  = {12'b0, b[3:0]};
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
               open_len  = SEQ_FOUR;
               need_cont = 2'd3;
               gathered  = '0;
            end else begin
               halted = 1'b1;
            end
            if (!halted && open_len != SEQ_NONE && item.last) halted = 1'b1;
         end else begin
            if (open_len != SEQ_FOUR && (b & CONT_MASK) != CONT_CODE) begin
               halted = 1'b1;
            end else begin
               if (open_len != SEQ_FOUR) gathered = {gathered[9:0], b[5:0]};
               need_cont = need_cont - 2'd1;
               if (need_cont != 0) begin
                  if (item.last) halted = 1'b1;
               end else if (open_len == SEQ_TWO && gathered < MIN_TWO_BYTE) begin
                  halted = 1'b1;
               end else if (open_len == SEQ_THREE && gathered < MIN_THREE_BYTE) begin
                  halted = 1'b1;
               end else begin
                  case (open_len)
                     SEQ_TWO:   span = 2;
                     SEQ_THREE: span = 3;
                     default:   span = 4;
                  endcase
                  cnt_bytes = sat_add(cnt_bytes, 32'(span));
                  if (open_len != SEQ_FOUR) begin
                     ch   = gathered;
                     emit = 1'b1;
                  end
                  open_len = SEQ_NONE;
                  gathered = '0;
               end
            end
         end
         if (emit) cnt_chars = sat_add(cnt_chars, 32'd1);
      end
      has_res = emit || item.last;
      if (has_res) begin
         res.char_valid = emit;
         res.character  = ch;
         res.done_res   = item.last;
         if (item.last) begin
            res.bytes_consumed  = cnt_bytes;
            res.characters_made = cnt_chars;
            clear_buffer_state();
         end
      end
   endtask

   always @(posedge clock) begin : watch
      u8dec_rsp_type want;
      u8dec_rsp_type made;
      bit            has_res;
      if (reset) begin
         char_limit = OUT_MAX;
         clear_buffer_state();
         expected_q.delete();
      end else begin
         if (csr_wr_en) char_limit = csr_wr_data;
         if (req_valid && req_ready) begin
            decode_byte(req_data, has_res, made);
            if (has_res) expected_q.push_back(made);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected transaction", 32'd0, {16'h0, rsp_data.character});
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.char_valid !== want.char_valid)
                  report("char_valid", 32'(want.char_valid), 32'(rsp_data.char_valid));
               if (rsp_data.character !== want.character)
                  report("character", 32'(want.character), 32'(rsp_data.character));
               if (rsp_data.done_res !== want.done_res)
                  report("done_res", 32'(want.done_res), 32'(rsp_data.done_res));
               if (rsp_data.bytes_consumed !== want.bytes_consumed)
                  report("bytes_consumed", want.bytes_consumed, rsp_data.bytes_consumed);
               if (rsp_data.characters_made !== want.characters_made)
                  report("characters_made", want.characters_made, rsp_data.characters_made);
            end
         end
      end
      waiting <= expected_q.size();
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// testbench top: byte stimulus, capacity phases and final verdict for the utf-8 decoder
module testbench;
   import u8dec_pkg::*;

   localparam int DRAIN_CYCLES = 8;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   u8dec_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   u8dec_rsp_type rsp_data;
   logic          csr_wr_en = 1'b0;
   logic [31:0]   csr_wr_data = '0;
   int            mismatches;
   int            pending;

   logic [7:0]    buf_bytes[$];
   bit            quiet = 1'b0;
   int            sent = 0;
   int            stall_left = 0;
   int            calm_left = 0;

   always #2 clock = ~clock;

   utf8_to_ucs2_stream_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ucs2_result_monitor result_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (pending)
   );

   // receiver back-pressure: short and long stalls, with calm stretches
   always @(posedge clock) begin : ready_gen
      int r;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 20) stall_left = $urandom_range(1, 3);
            else if (r < 23) stall_left = $urandom_range(10, 40);
            else if (r < 27) calm_left = $urandom_range(30, 100);
         end
      end
   end

   function automatic int idle_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic is_last);
      int            gap;
      u8dec_req_type item;
      gap = idle_len();
      item.data_byte = value;
      item.last      = is_last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_buffer();
      foreach (buf_bytes[i]) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
   endtask

   // wait out every expected transaction, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly well-formed sequences with random content, some broken or noise
   task automatic build_random_buffer();
      int          seq_count;
      int          r;
      logic [15:0] code;
      logic [7:0]  b;
      buf_bytes.delete();
      seq_count = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      repeat (seq_count) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            buf_bytes.push_back(8'($urandom_range(0, 127)));
         end else if (r < 50) begin
            code = 16'($urandom_range(16'h0080, 16'h07FF));
            buf_bytes.push_back({3'b110, code[10:6]});
            buf_bytes.push_back({2'b10, code[5:0]});
         end else if (r < 72) begin
            code = 16'($urandom_range(16'h0800, 16'hFFFF));
            buf_bytes.push_back({4'b1110, code[15:12]});
            buf_bytes.push_back({2'b10, code[11:6]});
            buf_bytes.push_back({2'b10, code[5:0]});
         end else if (r < 80) begin
            buf_bytes.push_back({5'b11110, 3'($urandom_range(0, 7))});
            repeat (3) buf_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (r < 86) begin
            if ($urandom_range(0, 1) == 0) begin
               code = 16'($urandom_range(0, 16'h007F));
               buf_bytes.push_back({3'b110, code[10:6]});
            end else begin
               code = 16'($urandom_range(0, 16'h07FF));
               buf_bytes.push_back({4'b1110, code[15:12]});
               buf_bytes.push_back({2'b10, code[11:6]});
            end
            buf_bytes.push_back({2'b10, code[5:0]});
         end else if (r < 92) begin
            if ($urandom_range(0, 1) == 0) buf_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            else buf_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            b = 8'($urandom_range(0, 191));
            if (b >= 8'd128) b = b + 8'd64;
            buf_bytes.push_back(b);
         end else begin
            buf_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      // cut the final byte off the buffer now and then
      if (buf_bytes.size() > 1 && $urandom_range(0, 9) == 0) void'(buf_bytes.pop_back());
   endtask

   initial begin : stimulus
      logic [31:0] limits[7];
      int          quota[7];
      int          phase_end;
      limits = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0005,
                 32'($urandom_range(3, 40)), 32'hFFFF_FFFE, 32'hFFFF_FFFF};
      quota  = '{60, 80, 200, 200, 200, 350, 360};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: range extremes of each length, four-byte skip, surrogate
      buf_bytes = '{8'h00, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hEF, 8'hBF,
                    8'hBF, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'hFF, 8'h00, 8'h80, 8'h7F};
      send_buffer();
      // overlong two-byte, then absorbed bytes
      buf_bytes = '{8'hC1, 8'hBF, 8'h41};
      send_buffer();
      // overlong three-byte
      buf_bytes = '{8'hE0, 8'h9F, 8'hBF};
      send_buffer();
      // bad continuation
      buf_bytes = '{8'hC3, 8'h28};
      send_buffer();
      // truncated at buffer end
      buf_bytes = '{8'hE1, 8'h80};
      send_buffer();
      // invalid lead byte
      buf_bytes = '{8'hFF};
      send_buffer();
      settle();

      foreach (limits[p]) begin
         write_limit(limits[p]);
         if (limits[p] == 32'h0) begin
            // zero capacity refuses even a four-byte lead
            buf_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80};
            send_buffer();
         end
         phase_end = sent + quota[p];
         while (sent < phase_end) begin
            quiet = ($urandom_range(0, 7) == 0);
            build_random_buffer();
            send_buffer();
         end
         quiet = 1'b0;
         settle();
      end

      if (mismatches == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
